/* rtl/core/hevc_subpel_interp_filter_assert.svh */
// Assertion macros shared by the interpolation filter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef HEVC_SUBPEL_INTERP_FILTER_ASSERT_SVH
`define HEVC_SUBPEL_INTERP_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HSPI_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define HSPI_ASSERT_DELAY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("latency check failed");
`else
`define HSPI_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define HSPI_ASSERT_DELAY(label, clk, rst_n, a, n, b)
`endif
`endif

/* rtl/core/hspi_pkg.sv */
// Types, constants and coefficient tables of the interpolation filter.
// No dependencies; imported by every module of the block.
package hspi_pkg;

    localparam int LUMA_TAPS   = 8;
    localparam int CHROMA_TAPS = 4;
    localparam int CHROMA_BASE = 2;
    localparam int LUMA_PHASES = 4;
    localparam int CHROMA_PHASES = 8;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = 24;
    localparam int PART_W   = 26;
    localparam int ACC_W    = 28;
    localparam int OFF_W    = 21;
    localparam int SH_W     = 4;
    localparam int DEPTH_W  = 4;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LUMA_DEPTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_DEPTH = 2'd1;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd14;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;

    localparam logic [SH_W-1:0] PREC_INT  = 4'd14;
    localparam logic [SH_W-1:0] PREC_FILT = 4'd6;

    localparam logic signed [OFF_W-1:0]    OFFS_W    = 21'sd8192;
    localparam logic signed [SAMPLE_W-1:0] OFFS_16   = 16'sd8192;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t LUMA_TAB [LUMA_PHASES][LUMA_TAPS] = '{
        '{ 8'sd0,  8'sd0,  8'sd0,   8'sd64, 8'sd0,  8'sd0,   8'sd0,  8'sd0  },
        '{-8'sd1,  8'sd4, -8'sd10,  8'sd58, 8'sd17, -8'sd5,  8'sd1,  8'sd0  },
        '{-8'sd1,  8'sd4, -8'sd11,  8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1  },
        '{ 8'sd0,  8'sd1, -8'sd5,   8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1  }
    };

    localparam coef_t CHROMA_TAB [CHROMA_PHASES][CHROMA_TAPS] = '{
        '{ 8'sd0, 8'sd64, 8'sd0,   8'sd0 },
        '{-8'sd2, 8'sd58, 8'sd10, -8'sd2 },
        '{-8'sd4, 8'sd54, 8'sd16, -8'sd2 },
        '{-8'sd6, 8'sd46, 8'sd28, -8'sd4 },
        '{-8'sd4, 8'sd36, 8'sd36, -8'sd4 },
        '{-8'sd4, 8'sd28, 8'sd46, -8'sd6 },
        '{-8'sd2, 8'sd16, 8'sd54, -8'sd4 },
        '{-8'sd2, 8'sd10, 8'sd58, -8'sd2 }
    };

    typedef struct packed {
        logic                       copy;
        logic signed [SAMPLE_W-1:0] cval;
        logic signed [OFF_W-1:0]    off;
        logic [SH_W-1:0]            sh;
        logic                       clip_en;
        logic [DEPTH_W-1:0]         depth;
    } hspi_ctrl_t;

    function automatic logic signed [OFF_W-1:0] round_half(input logic [SH_W-1:0] sh);
        logic signed [OFF_W-1:0] r;
        if (sh == '0)
        begin
            r = '0;
        end
        else
        begin
            r = OFF_W'(1) << (sh - SH_W'(1));
        end
        return r;
    endfunction

    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] r;
        priority if (d < DEPTH_MIN)
        begin
            r = DEPTH_MIN;
        end
        else if (d > DEPTH_MAX)
        begin
            r = DEPTH_MAX;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

/* rtl/core/hspi_lane.sv */
// One multiply lane: picks its tap coefficient for the phase and registers the product.
// Depends on hspi_pkg.
module hspi_lane
    import hspi_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic                       clk,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [PHASE_W-1:0]         phase,
    input  logic                       chroma,
    output logic signed [PROD_W-1:0]   prod
);

    localparam bit IS_CHROMA_LANE = (LANE >= CHROMA_BASE) && (LANE < CHROMA_BASE + CHROMA_TAPS);

    coef_t                      luma_coef;
    coef_t                      chroma_coef;
    coef_t                      coef;
    logic signed [PROD_W-1:0]   samp_ext;
    logic signed [PROD_W-1:0]   coef_ext;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;

    assign luma_coef = LUMA_TAB[phase[1:0]][LANE];

    generate
        if (IS_CHROMA_LANE)
        begin : g_chroma
            assign chroma_coef = CHROMA_TAB[phase][LANE - CHROMA_BASE];
        end
        else
        begin : g_no_chroma
            assign chroma_coef = '0;
        end
    endgenerate

    assign coef      = chroma ? chroma_coef : luma_coef;
    assign samp_ext  = PROD_W'(sample);
    assign coef_ext  = PROD_W'(coef);
    assign prod_next = samp_ext * coef_ext;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/hspi_merge.sv */
// Merge stage: sums products (or copy value), adds offset, shifts, wraps, may clip.
// Depends on hspi_pkg and hevc_subpel_interp_filter_assert.svh.
`include "hevc_subpel_interp_filter_assert.svh"
module hspi_merge
    import hspi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  hspi_ctrl_t                 in_ctrl,
    input  logic signed [PROD_W-1:0]   prod [LUMA_TAPS],
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    localparam int HALF = LUMA_TAPS / 2;

    logic                       v2_reg, v3_reg;
    hspi_ctrl_t                 c2_reg, c3_reg;
    logic signed [PART_W-1:0]   part_a_next, part_b_next;
    logic signed [PART_W-1:0]   part_a_reg, part_b_reg;
    logic signed [ACC_W-1:0]    acc_next, acc_reg;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [SAMPLE_W-1:0] wrapped;
    logic [SAMPLE_W-1:0]        maxv;
    logic signed [SAMPLE_W-1:0] res_next, res_reg;

    always_comb
    begin
        part_a_next = '0;
        part_b_next = '0;
        for (int i = 0; i < HALF; i++)
        begin
            part_a_next = part_a_next + PART_W'(prod[i]);
            part_b_next = part_b_next + PART_W'(prod[i + HALF]);
        end
        if (in_ctrl.copy)
        begin
            part_a_next = PART_W'(in_ctrl.cval);
            part_b_next = '0;
        end
    end

    assign acc_next = ACC_W'(part_a_reg) + ACC_W'(part_b_reg) + ACC_W'(c2_reg.off);

    always_comb
    begin
        shifted = acc_reg >>> c3_reg.sh;
        wrapped = shifted[SAMPLE_W-1:0];
        maxv    = (SAMPLE_W'(1) << c3_reg.depth) - SAMPLE_W'(1);
        res_next = wrapped;
        if (c3_reg.clip_en)
        begin
            priority if (wrapped < 0)
            begin
                res_next = '0;
            end
            else if (wrapped > $signed(maxv))
            begin
                res_next = $signed(maxv);
            end
            else
            begin
                res_next = wrapped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v2_reg    <= in_valid;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c2_reg     <= in_ctrl;
        part_a_reg <= part_a_next;
        part_b_reg <= part_b_next;
        c3_reg     <= c2_reg;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    assign out_sample = res_reg;

    `HSPI_ASSERT_DELAY(a_latency, clk, rst_n, in_valid, 3, out_valid)
    `HSPI_ASSERT_IMPLY(a_clip_low, clk, rst_n, v3_reg && c3_reg.clip_en, !res_next[SAMPLE_W-1])
    `HSPI_ASSERT_IMPLY(a_clip_high, clk, rst_n, v3_reg && c3_reg.clip_en, res_next <= $signed(maxv))

endmodule

/* rtl/core/hevc_subpel_interp_filter.sv */
// Top level of the HEVC sub-sample interpolation filter: config registers,
// pass decode, eight multiply lanes and the merge stage. Depends on hspi_pkg.
//
//  channel   handshake                 payload
//  input     start (busy is low)       win_m3..win_p4, frac, is_chroma, is_first, is_last
//  result    done, one cycle           out_sample
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One item per cycle; a start passes the lane multiply, two-level sum, offset add and
// shift/clip registers in that order before done rises with out_sample.
// busy stays low: the pipeline never stalls, and the receiver cannot stall.
// Reset sets both bit depths to 8 and empties the pipeline.
module hevc_subpel_interp_filter
    import hspi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] win_m3,
    input  logic signed [SAMPLE_W-1:0] win_m2,
    input  logic signed [SAMPLE_W-1:0] win_m1,
    input  logic signed [SAMPLE_W-1:0] win_0,
    input  logic signed [SAMPLE_W-1:0] win_p1,
    input  logic signed [SAMPLE_W-1:0] win_p2,
    input  logic signed [SAMPLE_W-1:0] win_p3,
    input  logic signed [SAMPLE_W-1:0] win_p4,
    input  logic [PHASE_W-1:0]         frac,
    input  logic                       is_chroma,
    input  logic                       is_first,
    input  logic                       is_last,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] out_sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DEPTH_W-1:0]         cfg_data
);

    logic [DEPTH_W-1:0]         luma_depth_reg, luma_depth_next;
    logic [DEPTH_W-1:0]         chroma_depth_reg, chroma_depth_next;
    logic                       accept;
    logic                       v1_reg;
    hspi_ctrl_t                 ctrl_next, ctrl_reg;
    logic [DEPTH_W-1:0]         depth;
    logic [SH_W-1:0]            head;
    logic [PHASE_W-1:0]         phase;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [SH_W-1:0]            sh_f;
    logic signed [SAMPLE_W-1:0] win [LUMA_TAPS];
    logic signed [PROD_W-1:0]   prod [LUMA_TAPS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        luma_depth_next   = luma_depth_reg;
        chroma_depth_next = chroma_depth_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LUMA_DEPTH:   luma_depth_next   = cfg_data;
                REG_CHROMA_DEPTH: chroma_depth_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        depth  = clamp_depth(is_chroma ? chroma_depth_reg : luma_depth_reg);
        head   = PREC_INT - depth;
        phase  = is_chroma ? frac : {1'b0, frac[1:0]};
        scaled = win_0 <<< head;
        sh_f   = '0;

        ctrl_next.copy    = (phase == '0);
        ctrl_next.depth   = depth;
        ctrl_next.cval    = win_0;
        ctrl_next.off     = '0;
        ctrl_next.sh      = '0;
        ctrl_next.clip_en = 1'b0;

        if (phase == '0)
        begin
            if (is_first && !is_last)
            begin
                ctrl_next.cval = scaled - OFFS_16;
            end
            else if (is_last && !is_first)
            begin
                ctrl_next.sh      = head;
                ctrl_next.off     = OFFS_W + round_half(head);
                ctrl_next.clip_en = 1'b1;
            end
        end
        else
        begin
            if (is_last)
            begin
                sh_f = is_first ? PREC_FILT : PREC_FILT + head;
                ctrl_next.off     = is_first ? round_half(sh_f)
                                             : round_half(sh_f) + (OFFS_W <<< PREC_FILT);
                ctrl_next.clip_en = 1'b1;
            end
            else
            begin
                sh_f = is_first ? PREC_FILT - head : PREC_FILT;
                ctrl_next.off = is_first ? -(OFFS_W <<< sh_f) : '0;
            end
            ctrl_next.sh = sh_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_depth_reg   <= DEPTH_RESET;
            chroma_depth_reg <= DEPTH_RESET;
            v1_reg           <= 1'b0;
        end
        else
        begin
            luma_depth_reg   <= luma_depth_next;
            chroma_depth_reg <= chroma_depth_next;
            v1_reg           <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
    end

    assign win[0] = win_m3;
    assign win[1] = win_m2;
    assign win[2] = win_m1;
    assign win[3] = win_0;
    assign win[4] = win_p1;
    assign win[5] = win_p2;
    assign win[6] = win_p3;
    assign win[7] = win_p4;

    generate
        for (genvar g = 0; g < LUMA_TAPS; g++)
        begin : g_lane
            hspi_lane #(
                .LANE (g)
            ) u_lane (
                .clk    (clk),
                .sample (win[g]),
                .phase  (phase),
                .chroma (is_chroma),
                .prod   (prod[g])
            );
        end
    endgenerate

    hspi_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg),
        .in_ctrl    (ctrl_reg),
        .prod       (prod),
        .out_valid  (done),
        .out_sample (out_sample)
    );

endmodule
